// ===== hdl/gsp_pkg.sv =====
package gsp_pkg;

  localparam int CoordW  = 24;
  localparam int TapW    = 16;
  localparam int NumTaps = 8;
  localparam int TapIdxW = 3;
  localparam int ProdW   = CoordW + TapW + 1;
  // up to 15 products summed
  localparam int AccW    = ProdW + 4;
  localparam int FracW   = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     end_of_sequence;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] smooth_x;
    logic signed [CoordW-1:0] smooth_y;
    logic signed [CoordW-1:0] smooth_z;
    logic                     final_output;
  } smooth_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } coord3_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } lane_ctl_t;

  typedef struct packed {
    logic load;
    logic last;
  } merge_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_WRITE
  } state_t;

endpackage

// ===== hdl/gsp_lane.sv =====
module gsp_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gsp_pkg::lane_ctl_t                   ctl,
  input  logic signed [gsp_pkg::CoordW-1:0]    value,
  input  logic        [gsp_pkg::TapW-1:0]      tap,
  output logic signed [gsp_pkg::AccW-1:0]      acc
);

  logic signed [gsp_pkg::CoordW-1:0] op_val;
  logic        [gsp_pkg::TapW-1:0]   op_tap;
  logic                              op_vld;
  logic signed [gsp_pkg::ProdW-1:0]  prod;
  logic                              prod_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      op_vld   <= ctl.issue;
      prod_vld <= op_vld;
    end
  end

  // operand, product and accumulate stages
  always_ff @(posedge clk) begin
    op_val <= value;
    op_tap <= tap;
    prod   <= gsp_pkg::ProdW'(op_val) * gsp_pkg::ProdW'($signed({1'b0, op_tap}));
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + gsp_pkg::AccW'(prod);
    end
  end

endmodule

// ===== hdl/gsp_merge.sv =====
module gsp_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  gsp_pkg::merge_ctl_t               ctl,
  input  logic signed [gsp_pkg::AccW-1:0]   acc_x,
  input  logic signed [gsp_pkg::AccW-1:0]   acc_y,
  input  logic signed [gsp_pkg::AccW-1:0]   acc_z,
  output logic                              busy,
  output gsp_pkg::smooth_t                  smooth,
  output logic                              smooth_valid,
  input  logic                              smooth_stall
);

  localparam int SumW = gsp_pkg::AccW + 1;
  localparam int QW   = SumW - gsp_pkg::FracW;

  // round half up, then clamp to the coordinate range
  function automatic logic signed [gsp_pkg::CoordW-1:0] round_sat(
    input logic signed [gsp_pkg::AccW-1:0] a
  );
    logic signed [SumW-1:0] t;
    logic signed [QW-1:0]   q;
    logic signed [QW-1:0]   hi;
    logic signed [QW-1:0]   lo;
    logic signed [gsp_pkg::CoordW-1:0] r;
    t  = SumW'(a) + SumW'(1 << (gsp_pkg::FracW - 1));
    q  = t[SumW-1:gsp_pkg::FracW];
    hi = QW'((1 << (gsp_pkg::CoordW - 1)) - 1);
    lo = -hi - QW'(1);
    if (q > hi) begin
      r = hi[gsp_pkg::CoordW-1:0];
    end else if (q < lo) begin
      r = lo[gsp_pkg::CoordW-1:0];
    end else begin
      r = q[gsp_pkg::CoordW-1:0];
    end
    return r;
  endfunction

  assign busy = smooth_valid && smooth_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_valid <= 1'b0;
    end else if (ctl.load) begin
      smooth_valid <= 1'b1;
    end else if (!smooth_stall) begin
      smooth_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      smooth.smooth_x     <= round_sat(acc_x);
      smooth.smooth_y     <= round_sat(acc_y);
      smooth.smooth_z     <= round_sat(acc_z);
      smooth.final_output <= ctl.last;
    end
  end

endmodule

// ===== hdl/gaussian_smoothing_3d_points_top.sv =====
// channel   | valid         | stall         | payload
// ----------+---------------+---------------+-------------------------------
// point in  | point_valid   | point_stall   | point  (gsp_pkg::point_t)
// smooth out| smooth_valid  | smooth_stall  | smooth (gsp_pkg::smooth_t)
// config    | cfg_we        | none          | cfg_index, cfg_data
//
// A point that yields no result leaves the block idle for the next one. For each
// result (H = MAX_HALF_WINDOW), three per-coordinate lanes step one shared
// multiplier each through the 2H+1 taps, then a pipeline drain and a write.
// End of sequence emits up to H+1 results back to back in that way.
// Sync reset clears control and the point count and sets the taps to an impulse;
// the window holds junk.
// A result waits in the output register under smooth_stall; a new point
// is still taken meanwhile while the block is idle, but the next write waits.
module gaussian_smoothing_3d_points_top #(
  parameter int MAX_HALF_WINDOW = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gsp_pkg::point_t                     point,
  input  logic                                point_valid,
  output logic                                point_stall,
  output gsp_pkg::smooth_t                    smooth,
  output logic                                smooth_valid,
  input  logic                                smooth_stall,
  input  logic                                cfg_we,
  input  logic [gsp_pkg::TapIdxW-1:0]         cfg_index,
  input  logic [gsp_pkg::TapW-1:0]            cfg_data
);

  localparam int H     = MAX_HALF_WINDOW;
  localparam int Depth = 2 * H + 1;
  localparam int SeenW = $clog2(Depth + 1);
  localparam int AgeW  = (H + 1 > 2) ? $clog2(H + 1) : 1;
  localparam int CntW  = $clog2(Depth + 2);
  localparam int QW    = CntW + 2;
  localparam int IdxW  = $clog2(Depth);

  gsp_pkg::state_t   state, state_next;
  logic [CntW-1:0]   cnt, cnt_next;
  logic [AgeW-1:0]   age, age_next;
  logic              flush, flush_next;
  logic [SeenW-1:0]  seen, seen_next;
  logic [SeenW-1:0]  calc_seen, calc_seen_next;
  logic [SeenW-1:0]  seen_inc;

  logic [gsp_pkg::TapW-1:0] taps [gsp_pkg::NumTaps];
  gsp_pkg::coord3_t         win  [Depth];

  logic                     accept;
  logic                     out_busy;
  gsp_pkg::lane_ctl_t       lctl;
  gsp_pkg::merge_ctl_t      mctl;
  logic [QW-1:0]            q;
  logic [IdxW-1:0]          sel_idx;
  logic [CntW-1:0]          k;
  gsp_pkg::coord3_t         sel_pt;
  logic [gsp_pkg::TapW-1:0] sel_tap;
  logic signed [gsp_pkg::AccW-1:0] acc_x, acc_y, acc_z;

  assign point_stall = (state != gsp_pkg::S_IDLE);
  assign accept      = point_valid && !point_stall;
  assign seen_inc    = (seen < SeenW'(Depth)) ? seen + 1'b1 : seen;

  // window position of offset j for the point of age 'age'; q = age - j
  always_comb begin
    q = QW'(age) + QW'(H) - QW'(cnt);
    if (q[QW-1]) begin
      sel_idx = '0;                       // past the newest point
    end else if (q[QW-2:0] >= (QW-1)'(calc_seen)) begin
      sel_idx = IdxW'(age);               // before sequence start
    end else begin
      sel_idx = q[IdxW-1:0];
    end
    k       = (cnt >= CntW'(H)) ? cnt - CntW'(H) : CntW'(H) - cnt;
    sel_pt  = win[sel_idx];
    sel_tap = taps[k[gsp_pkg::TapIdxW-1:0]];
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    age_next       = age;
    flush_next     = flush;
    seen_next      = seen;
    calc_seen_next = calc_seen;
    mctl           = '0;
    case (state)
      gsp_pkg::S_IDLE: begin
        if (accept) begin
          seen_next      = seen_inc;
          calc_seen_next = seen_inc;
          cnt_next       = '0;
          if (point.end_of_sequence) begin
            seen_next  = '0;
            flush_next = 1'b1;
            age_next   = (seen_inc > SeenW'(H)) ? AgeW'(H) : AgeW'(seen_inc - 1'b1);
            state_next = gsp_pkg::S_CALC;
          end else if (seen_inc > SeenW'(H)) begin
            flush_next = 1'b0;
            age_next   = AgeW'(H);
            state_next = gsp_pkg::S_CALC;
          end
        end
      end
      gsp_pkg::S_CALC: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CntW'(Depth + 1)) begin
          state_next = gsp_pkg::S_WRITE;
        end
      end
      gsp_pkg::S_WRITE: begin
        if (!out_busy) begin
          mctl.load = 1'b1;
          mctl.last = flush && (age == '0);
          if (flush && (age != '0)) begin
            age_next   = age - 1'b1;
            cnt_next   = '0;
            state_next = gsp_pkg::S_CALC;
          end else begin
            state_next = gsp_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = gsp_pkg::S_IDLE;
      end
    endcase
  end

  assign lctl.issue = (state == gsp_pkg::S_CALC) && (cnt < CntW'(Depth));
  assign lctl.clear = (state == gsp_pkg::S_CALC) && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsp_pkg::S_IDLE;
      seen  <= '0;
      for (int i = 0; i < gsp_pkg::NumTaps; i++) begin
        taps[i] <= (i == 0) ? {gsp_pkg::TapW{1'b1}} : {gsp_pkg::TapW{1'b0}};
      end
    end else begin
      state <= state_next;
      seen  <= seen_next;
      if (cfg_we) begin
        taps[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    age       <= age_next;
    flush     <= flush_next;
    calc_seen <= calc_seen_next;
    if (accept) begin
      win[0] <= '{x: point.point_x, y: point.point_y, z: point.point_z};
      for (int i = 1; i < Depth; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  gsp_lane u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lctl),
    .value (sel_pt.x),
    .tap   (sel_tap),
    .acc   (acc_x)
  );

  gsp_lane u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lctl),
    .value (sel_pt.y),
    .tap   (sel_tap),
    .acc   (acc_y)
  );

  gsp_lane u_lane_z (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lctl),
    .value (sel_pt.z),
    .tap   (sel_tap),
    .acc   (acc_z)
  );

  gsp_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mctl),
    .acc_x        (acc_x),
    .acc_y        (acc_y),
    .acc_z        (acc_z),
    .busy         (out_busy),
    .smooth       (smooth),
    .smooth_valid (smooth_valid),
    .smooth_stall (smooth_stall)
  );

`ifndef SYNTHESIS
  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    mctl.load |-> !(smooth_valid && smooth_stall))
    else $error("result loaded over a stalled transaction");

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    seen <= SeenW'(Depth))
    else $error("point count out of range");

  a_eos_clears_seen: assert property (@(posedge clk) disable iff (rst)
    (accept && point.end_of_sequence) |=> (seen == '0))
    else $error("point count not cleared at end of sequence");

  a_final_only_on_flush: assert property (@(posedge clk) disable iff (rst)
    mctl.last |-> (flush && (state == gsp_pkg::S_WRITE)))
    else $error("final flag outside a flush");
`endif

endmodule

// ===== sim/gaussian_smoothing_3d_points_top_tb.sv =====
module gaussian_smoothing_3d_points_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HalfWin = 7;
  localparam int WinDepth = 2 * HalfWin + 1;
  localparam longint CoordMax = (longint'(1) << (gsp_pkg::CoordW - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;
  // per-result pipeline plus margin for points still in flight
  localparam int DrainCycles = 2 * HalfWin + 4 + 16;
  localparam int PhaseItems = 24;

  typedef enum int {
    TAPS_IMPULSE,
    TAPS_HALF,
    TAPS_FULL,
    TAPS_GAUSS,
    TAPS_ZERO,
    TAPS_RANDOM
  } tap_profile_t;

  class smoothing_scoreboard;
    logic [gsp_pkg::TapW-1:0] taps [gsp_pkg::NumTaps];
    gsp_pkg::coord3_t window [WinDepth];
    int unsigned seen;
    gsp_pkg::smooth_t pending_smooth [$];
    int errors;

    function new();
      foreach (taps[i]) taps[i] = '0;
      taps[0] = 16'hFFFF;
      foreach (window[i]) window[i] = '0;
      seen = 0;
      errors = 0;
    endfunction

    function void set_tap(int idx, logic [gsp_pkg::TapW-1:0] val);
      taps[idx] = val;
    endfunction

    function int outstanding();
      return pending_smooth.size();
    endfunction

    function longint coord_pick(gsp_pkg::coord3_t p, int c);
      case (c)
        0: return longint'(p.x);
        1: return longint'(p.y);
        default: return longint'(p.z);
      endcase
    endfunction

    function logic [gsp_pkg::CoordW-1:0] round_clamp(longint acc);
      longint q;
      q = (acc + 32768) >>> gsp_pkg::FracW;  // floor after +0.5: ties go up
      if (q > CoordMax) q = CoordMax;
      else if (q < CoordMin) q = CoordMin;
      return q[gsp_pkg::CoordW-1:0];
    endfunction

    // smoothed value of the point 'age' places back from the newest
    function gsp_pkg::smooth_t smooth_point(int age, bit last);
      gsp_pkg::smooth_t r;
      logic [gsp_pkg::CoordW-1:0] res [3];
      longint acc;
      longint v;
      int q;
      int k;
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int j = -HalfWin; j <= HalfWin; j++) begin
          q = age - j;
          k = (j < 0) ? -j : j;
          if (q < 0) v = coord_pick(window[0], c);
          else if (q >= int'(seen) || q >= WinDepth) v = coord_pick(window[age], c);
          else v = coord_pick(window[q], c);
          acc += v * longint'(taps[k]);
        end
        res[c] = round_clamp(acc);
      end
      r.smooth_x = res[0];
      r.smooth_y = res[1];
      r.smooth_z = res[2];
      r.final_output = last;
      return r;
    endfunction

    function void note_point(gsp_pkg::point_t p);
      int first;
      for (int i = WinDepth - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = {p.point_x, p.point_y, p.point_z};
      if (seen < WinDepth) seen++;
      if (p.end_of_sequence) begin
        first = int'(seen) - 1;
        if (first > HalfWin) first = HalfWin;
        for (int i = first; i >= 0; i--)
          pending_smooth = {pending_smooth, smooth_point(i, i == 0)};
        seen = 0;
      end else if (int'(seen) > HalfWin) begin
        pending_smooth = {pending_smooth, smooth_point(HalfWin, 1'b0)};
      end
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 40)
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task check_result(gsp_pkg::smooth_t got);
      gsp_pkg::smooth_t want;
      if (pending_smooth.size() == 0) begin
        report_mismatch("unexpected result, smooth_x", got.smooth_x, 0);
        return;
      end
      want = pending_smooth.pop_front();
      if (got.smooth_x !== want.smooth_x)
        report_mismatch("smooth_x", got.smooth_x, want.smooth_x);
      if (got.smooth_y !== want.smooth_y)
        report_mismatch("smooth_y", got.smooth_y, want.smooth_y);
      if (got.smooth_z !== want.smooth_z)
        report_mismatch("smooth_z", got.smooth_z, want.smooth_z);
      if (got.final_output !== want.final_output)
        report_mismatch("final_output", got.final_output, want.final_output);
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  gsp_pkg::point_t point = '0;
  logic point_valid = 1'b0;
  logic point_stall;
  gsp_pkg::smooth_t smooth;
  logic smooth_valid;
  logic smooth_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [gsp_pkg::TapIdxW-1:0] cfg_index = '0;
  logic [gsp_pkg::TapW-1:0] cfg_data = '0;

  smoothing_scoreboard sb = new();
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  gaussian_smoothing_3d_points_top #(
    .MAX_HALF_WINDOW(HalfWin)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .point(point),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .smooth(smooth),
    .smooth_valid(smooth_valid),
    .smooth_stall(smooth_stall),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver stall pattern: clear stretches, light, heavy and solid stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: smooth_stall <= 1'b0;
      1: smooth_stall <= ($urandom_range(0, 3) == 0);
      2: smooth_stall <= 1'($urandom_range(0, 1));
      default: smooth_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && smooth_valid && !smooth_stall) sb.check_result(smooth);
  end

  function automatic gsp_pkg::point_t mk_point(longint x, longint y, longint z, bit eos);
    gsp_pkg::point_t p;
    p.point_x = x[gsp_pkg::CoordW-1:0];
    p.point_y = y[gsp_pkg::CoordW-1:0];
    p.point_z = z[gsp_pkg::CoordW-1:0];
    p.end_of_sequence = eos;
    return p;
  endfunction

  function automatic longint rand_coord();
    case ($urandom_range(0, 9))
      0: return CoordMax;
      1: return CoordMin;
      2: return 0;
      3: return longint'($urandom_range(0, 4095)) - 2048;
      4: return CoordMax - $urandom_range(0, 255);
      5: return CoordMin + $urandom_range(0, 255);
      default: return longint'($urandom());
    endcase
  endfunction

  function automatic gsp_pkg::point_t rand_point(bit eos);
    return mk_point(rand_coord(), rand_coord(), rand_coord(), eos);
  endfunction

  // one transaction on the point channel, with bursts and gaps
  task automatic offer_point(input gsp_pkg::point_t p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        point_valid <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    point <= p;
    point_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (!point_stall) break;
    end
    sb.note_point(p);
  endtask

  task automatic drain_results();
    @(negedge clk);
    point_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apply_profile(input tap_profile_t prof);
    logic [gsp_pkg::TapW-1:0] t [gsp_pkg::NumTaps];
    logic [gsp_pkg::TapW-1:0] gauss [gsp_pkg::NumTaps];
    gauss = '{16'd16384, 16'd12000, 16'd7000, 16'd3000, 16'd1000, 16'd300, 16'd80, 16'd20};
    for (int i = 0; i < gsp_pkg::NumTaps; i++) begin
      case (prof)
        TAPS_IMPULSE: t[i] = (i == 0) ? 16'hFFFF : 16'h0000;
        TAPS_HALF: t[i] = (i == 0) ? 16'h8000 : 16'h0000;
        TAPS_FULL: t[i] = 16'hFFFF;
        TAPS_GAUSS: t[i] = gauss[i];
        TAPS_ZERO: t[i] = 16'h0000;
        default: begin
          case ($urandom_range(0, 3))
            0: t[i] = 16'h0000;
            1: t[i] = 16'hFFFF;
            2: t[i] = gsp_pkg::TapW'($urandom_range(0, 8191));
            default: t[i] = gsp_pkg::TapW'($urandom());
          endcase
        end
      endcase
    end
    for (int i = 0; i < gsp_pkg::NumTaps; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[gsp_pkg::TapIdxW-1:0];
      cfg_data <= t[i];
      sb.set_tap(i, t[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input tap_profile_t prof);
    int sent;
    int seq_len;
    apply_profile(prof);
    sent = 0;
    while (sent < PhaseItems) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 9))
          0, 1: seq_len = $urandom_range(1, 3);
          2, 3, 4: seq_len = $urandom_range(4, 9);
          5, 6, 7: seq_len = $urandom_range(10, 16);
          default: seq_len = $urandom_range(17, 30);
        endcase
        for (int n = 0; n < seq_len; n++) offer_point(rand_point(n == seq_len - 1));
        sent += seq_len;
      end else begin
        // noise: end flag anywhere, sequences broken at random
        offer_point(rand_point($urandom_range(0, 3) == 0));
        sent++;
      end
    end
    offer_point(rand_point(1'b1));
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset taps: single-point sequences at the extremes, then a pair
    offer_point(mk_point(CoordMax, CoordMin, 0, 1'b1));
    offer_point(mk_point(CoordMin, CoordMax, -1, 1'b1));
    offer_point(mk_point(1, -1, 12345, 1'b0));
    offer_point(mk_point(-7, CoordMax, CoordMin, 1'b1));
    drain_results();

    // half-weight center tap: odd inputs land on rounding ties
    apply_profile(TAPS_HALF);
    offer_point(mk_point(-1, 1, CoordMax, 1'b0));
    offer_point(mk_point(1, -3, CoordMin, 1'b0));
    offer_point(mk_point(-3, 3, -5, 1'b0));
    offer_point(mk_point(3, -1, 5, 1'b1));
    drain_results();

    // tap sum far above one: outputs saturate both ways
    apply_profile(TAPS_FULL);
    for (int n = 0; n < 9; n++)
      offer_point(mk_point((n % 2) ? CoordMax : CoordMin, (n % 3) ? 1000 : CoordMax,
                           -n * 300, n == 8));
    drain_results();

    // exactly H+1 points: no steady result, the flush emits all H+1
    apply_profile(TAPS_GAUSS);
    for (int n = 0; n < HalfWin + 1; n++)
      offer_point(mk_point(n * 4097 - 20000, CoordMax - n, CoordMin + n * 77, n == HalfWin));
    drain_results();

    random_phase(TAPS_GAUSS);
    random_phase(TAPS_RANDOM);
    random_phase(TAPS_FULL);
    random_phase(TAPS_ZERO);
    random_phase(TAPS_RANDOM);
    random_phase(TAPS_IMPULSE);

    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
